/* sv/lrdi_pkg.sv */
// ----------------------------------------------------------------------------
// lrdi_pkg: shared types and constants
// Register indexes, reset values, interpolation mode codes and the
// configuration register bundle for the lidar ray depth interpolation gate.
// ----------------------------------------------------------------------------
package lrdi_pkg;

  localparam int DEPTH_W = 24;
  localparam int FRAC_W  = 16;
  localparam int STEP_W  = 16;
  localparam int RF_W    = 16;
  localparam int NOISE_W = 21;
  localparam int KIND_W  = 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX_STEP_V   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX_STEP_H   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_RANGE_FLOOR  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_RANGE_CEIL   = 3'd3;

  localparam logic [STEP_W-1:0]  RST_MAX_STEP_V   = 16'd1229;
  localparam logic [STEP_W-1:0]  RST_MAX_STEP_H   = 16'd1229;
  localparam logic [DEPTH_W-1:0] RST_RANGE_FLOOR  = 24'd1229;
  localparam logic [DEPTH_W-1:0] RST_RANGE_CEIL   = 24'd409600;

  localparam logic [KIND_W-1:0] KIND_BILINEAR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_VERTICAL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_HORIZ    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE     = 2'd3;

  typedef struct packed {
    logic [STEP_W-1:0]  max_step_v;
    logic [STEP_W-1:0]  max_step_h;
    logic [DEPTH_W-1:0] range_floor;
    logic [DEPTH_W-1:0] range_ceil;
  } cfg_regs_t;

endpackage

/* sv/lrdi_cfg_regs.sv */
// ----------------------------------------------------------------------------
// lrdi_cfg_regs: configuration register file
// Holds the step limits and range limits; writes to unknown indexes are
// dropped.
// ----------------------------------------------------------------------------
module lrdi_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                wr_en,
  input  logic [lrdi_pkg::CFG_IDX_W-1:0]      wr_index,
  input  logic [lrdi_pkg::CFG_DATA_W-1:0]     wr_data,
  output lrdi_pkg::cfg_regs_t                 regs
);
  import lrdi_pkg::*;

  cfg_regs_t regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.max_step_v  <= RST_MAX_STEP_V;
      regs_r.max_step_h  <= RST_MAX_STEP_H;
      regs_r.range_floor <= RST_RANGE_FLOOR;
      regs_r.range_ceil  <= RST_RANGE_CEIL;
    end else if (wr_en) begin
      case (wr_index)
        CFG_IDX_MAX_STEP_V:  regs_r.max_step_v  <= wr_data[STEP_W-1:0];
        CFG_IDX_MAX_STEP_H:  regs_r.max_step_h  <= wr_data[STEP_W-1:0];
        CFG_IDX_RANGE_FLOOR: regs_r.range_floor <= wr_data[DEPTH_W-1:0];
        CFG_IDX_RANGE_CEIL:  regs_r.range_ceil  <= wr_data[DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  assign regs = regs_r;

endmodule

/* sv/lidar_ray_depth_interpolate_gate_top.sv */
// ----------------------------------------------------------------------------
// lidar_ray_depth_interpolate_gate_top: edge-aware depth interpolation and
// range gate
// The block accepts one ray request per clock while the output is not
// stalled and drives one result per request on the output. The pipeline
// follows the chain of multiplications: step-limit products, column blends,
// row blends, noise addition, range product and the final range gate each own
// one of six register stages. A result held by an output stall freezes the
// whole pipeline, and the input is stalled in the same cycle. Configuration
// writes are always ready and should only be issued while no request is in
// flight.
// ----------------------------------------------------------------------------
module lidar_ray_depth_interpolate_gate_top (
  input  logic                                clk,
  input  logic                                rst_n,
  // request channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [lrdi_pkg::DEPTH_W-1:0]        in_depth_top_left,
  input  logic [lrdi_pkg::DEPTH_W-1:0]        in_depth_bottom_left,
  input  logic [lrdi_pkg::DEPTH_W-1:0]        in_depth_top_right,
  input  logic [lrdi_pkg::DEPTH_W-1:0]        in_depth_bottom_right,
  input  logic [lrdi_pkg::FRAC_W-1:0]         in_u_fraction,
  input  logic [lrdi_pkg::FRAC_W-1:0]         in_v_fraction,
  input  logic [lrdi_pkg::RF_W-1:0]           in_range_factor,
  input  logic signed [lrdi_pkg::NOISE_W-1:0] in_noise_sample,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [lrdi_pkg::DEPTH_W-1:0]        out_range_out,
  output logic [lrdi_pkg::DEPTH_W-1:0]        out_depth_out,
  output logic                                out_valid_res,
  output logic [lrdi_pkg::KIND_W-1:0]         out_interp_kind,
  // configuration channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lrdi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lrdi_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import lrdi_pkg::*;

  localparam int PROD_W  = DEPTH_W + STEP_W;      // step limit times depth
  localparam int BLEND_W = DEPTH_W + FRAC_W + 1;  // one-axis blend sum
  localparam int BIL_W   = BLEND_W + FRAC_W + 1;  // full bilinear sum
  localparam int DN_W    = DEPTH_W + 2;           // signed noisy depth
  localparam int RPROD_W = DEPTH_W + RF_W;
  localparam int RNG_W   = RPROD_W + 1 - 12;

  localparam logic [FRAC_W:0]    FRAC_ONE  = 17'h10000;
  localparam logic [BIL_W-1:0]   BIL_HALF  = BIL_W'(64'h8000_0000);
  localparam logic [BLEND_W-1:0] LIN_HALF  = BLEND_W'(32'h8000);
  localparam logic [RPROD_W:0]   RNG_HALF  = (RPROD_W+1)'(2048);

  cfg_regs_t cfg;

  assign cfg_ready = 1'b1;

  lrdi_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .regs     (cfg)
  );

  // The pipeline moves as one; it holds only when a result waits.
  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // ---------------- stage 1: differences and step-limit products ----------
  logic [DEPTH_W-1:0] dif_u0, dif_u1, dif_v0, dif_v1, au_c, av_c;

  always_comb begin
    dif_u0 = (in_depth_top_left > in_depth_top_right) ?
             in_depth_top_left - in_depth_top_right : in_depth_top_right - in_depth_top_left;
    dif_u1 = (in_depth_bottom_left > in_depth_bottom_right) ?
             in_depth_bottom_left - in_depth_bottom_right :
             in_depth_bottom_right - in_depth_bottom_left;
    dif_v0 = (in_depth_top_left > in_depth_bottom_left) ?
             in_depth_top_left - in_depth_bottom_left : in_depth_bottom_left - in_depth_top_left;
    dif_v1 = (in_depth_top_right > in_depth_bottom_right) ?
             in_depth_top_right - in_depth_bottom_right :
             in_depth_bottom_right - in_depth_top_right;
    au_c = (dif_u0 > dif_u1) ? dif_u0 : dif_u1;
    av_c = (dif_v0 > dif_v1) ? dif_v0 : dif_v1;
  end

  logic                       s1_vld_r;
  logic [DEPTH_W-1:0]         s1_d00_r, s1_d01_r, s1_d10_r, s1_d11_r;
  logic [FRAC_W-1:0]          s1_uf_r, s1_vf_r;
  logic [RF_W-1:0]            s1_rf_r;
  logic signed [NOISE_W-1:0]  s1_noise_r;
  logic [DEPTH_W-1:0]         s1_au_r, s1_av_r;
  logic [PROD_W-1:0]          s1_pv_r, s1_ph_r;

  // ---------------- stage 2: mode decision and column blends --------------
  logic               okv, oku;
  logic [KIND_W-1:0]  kind_c;
  logic [FRAC_W:0]    iu_c, iv_c;
  logic [DEPTH_W-1:0] lin_a, lin_b;
  logic [FRAC_W-1:0]  lin_f;
  logic [BLEND_W-1:0] a_sum_c, b_sum_c, lin_sum_c;

  always_comb begin
    okv = {4'b0, s1_av_r, 12'b0} < s1_pv_r;
    oku = {4'b0, s1_au_r, 12'b0} < s1_ph_r;
    if (okv && oku) begin
      kind_c = KIND_BILINEAR;
    end else if (okv) begin
      kind_c = KIND_VERTICAL;
    end else if (oku) begin
      kind_c = KIND_HORIZ;
    end else begin
      kind_c = KIND_NONE;
    end
    iu_c = FRAC_ONE - {1'b0, s1_uf_r};
    iv_c = FRAC_ONE - {1'b0, s1_vf_r};
    // Vertical-only takes the nearest column and blends along the rows;
    // otherwise the nearest row is blended along the columns.
    if (kind_c == KIND_VERTICAL) begin
      lin_a = s1_uf_r[FRAC_W-1] ? s1_d10_r : s1_d00_r;
      lin_b = s1_uf_r[FRAC_W-1] ? s1_d11_r : s1_d01_r;
      lin_f = s1_vf_r;
    end else begin
      lin_a = s1_vf_r[FRAC_W-1] ? s1_d01_r : s1_d00_r;
      lin_b = s1_vf_r[FRAC_W-1] ? s1_d11_r : s1_d10_r;
      lin_f = s1_uf_r;
    end
    a_sum_c   = BLEND_W'(s1_d00_r) * BLEND_W'(iu_c) + BLEND_W'(s1_d10_r) * BLEND_W'(s1_uf_r);
    b_sum_c   = BLEND_W'(s1_d01_r) * BLEND_W'(iu_c) + BLEND_W'(s1_d11_r) * BLEND_W'(s1_uf_r);
    lin_sum_c = BLEND_W'(lin_a) * BLEND_W'(FRAC_ONE - {1'b0, lin_f})
              + BLEND_W'(lin_b) * BLEND_W'(lin_f);
  end

  logic                       s2_vld_r;
  logic [KIND_W-1:0]          s2_kind_r;
  logic [BLEND_W-1:0]         s2_a_sum_r, s2_b_sum_r, s2_lin_sum_r;
  logic [FRAC_W:0]            s2_iv_r;
  logic [FRAC_W-1:0]          s2_vf_r;
  logic [DEPTH_W-1:0]         s2_d00_r;
  logic [RF_W-1:0]            s2_rf_r;
  logic signed [NOISE_W-1:0]  s2_noise_r;

  // ---------------- stage 3: row blend of the bilinear sum ----------------
  logic [BIL_W-1:0] bil_sum_c;

  assign bil_sum_c = BIL_W'(s2_a_sum_r) * BIL_W'(s2_iv_r)
                   + BIL_W'(s2_b_sum_r) * BIL_W'(s2_vf_r);

  logic                       s3_vld_r;
  logic [KIND_W-1:0]          s3_kind_r;
  logic [BIL_W-1:0]           s3_bil_sum_r;
  logic [BLEND_W-1:0]         s3_lin_sum_r;
  logic [DEPTH_W-1:0]         s3_d00_r;
  logic [RF_W-1:0]            s3_rf_r;
  logic signed [NOISE_W-1:0]  s3_noise_r;

  // ---------------- stage 4: rounding, noise and depth gate ---------------
  logic [BIL_W-1:0]      bil_rnd;
  logic [BLEND_W-1:0]    lin_rnd;
  logic [DEPTH_W-1:0]    d_sel, d_c;
  logic signed [DN_W-1:0] dn_c;
  logic                  ok_c;

  always_comb begin
    bil_rnd = s3_bil_sum_r + BIL_HALF;
    lin_rnd = s3_lin_sum_r + LIN_HALF;
    case (s3_kind_r)
      KIND_BILINEAR:           d_sel = bil_rnd[32 +: DEPTH_W];
      KIND_VERTICAL, KIND_HORIZ: d_sel = lin_rnd[16 +: DEPTH_W];
      default:                 d_sel = s3_d00_r;
    endcase
    dn_c = $signed({2'b0, d_sel}) + DN_W'(s3_noise_r);
    ok_c = 1'b1;
    d_c  = d_sel;
    // A zero depth means no return and takes no noise.
    if (d_sel != '0) begin
      if (dn_c[DN_W-1] || (dn_c[DN_W-2:0] > {1'b0, cfg.range_ceil})) begin
        ok_c = 1'b0;
      end else begin
        d_c = dn_c[DEPTH_W-1:0];
      end
    end
  end

  logic               s4_vld_r;
  logic [KIND_W-1:0]  s4_kind_r;
  logic [DEPTH_W-1:0] s4_d_r;
  logic               s4_ok_r;
  logic [RF_W-1:0]    s4_rf_r;

  // ---------------- stage 5: range product --------------------------------
  logic               s5_vld_r;
  logic [KIND_W-1:0]  s5_kind_r;
  logic [DEPTH_W-1:0] s5_d_r;
  logic               s5_ok_r;
  logic [RPROD_W-1:0] s5_prod_r;

  // ---------------- stage 6: rounding, saturation and range gate ----------
  logic [RPROD_W:0]   rprod_rnd;
  logic [RNG_W-1:0]   rng_wide;
  logic [DEPTH_W-1:0] rng_c;
  logic               res_ok_c;

  always_comb begin
    rprod_rnd = {1'b0, s5_prod_r} + RNG_HALF;
    rng_wide  = rprod_rnd[RPROD_W:12];
    rng_c     = (rng_wide[RNG_W-1:DEPTH_W] != '0) ? '1 : rng_wide[DEPTH_W-1:0];
    res_ok_c  = s5_ok_r && (rng_c > cfg.range_floor) && (rng_c < cfg.range_ceil);
  end

  logic               out_vld_r;
  logic [DEPTH_W-1:0] out_range_r, out_depth_r;
  logic               out_res_r;
  logic [KIND_W-1:0]  out_kind_r;

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      s4_vld_r  <= 1'b0;
      s5_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r  <= in_valid;
      s2_vld_r  <= s1_vld_r;
      s3_vld_r  <= s2_vld_r;
      s4_vld_r  <= s3_vld_r;
      s5_vld_r  <= s4_vld_r;
      out_vld_r <= s5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_d00_r   <= in_depth_top_left;
      s1_d01_r   <= in_depth_bottom_left;
      s1_d10_r   <= in_depth_top_right;
      s1_d11_r   <= in_depth_bottom_right;
      s1_uf_r    <= in_u_fraction;
      s1_vf_r    <= in_v_fraction;
      s1_rf_r    <= in_range_factor;
      s1_noise_r <= in_noise_sample;
      s1_au_r    <= au_c;
      s1_av_r    <= av_c;
      s1_pv_r    <= PROD_W'(cfg.max_step_v) * PROD_W'(in_depth_top_left);
      s1_ph_r    <= PROD_W'(cfg.max_step_h) * PROD_W'(in_depth_top_left);

      s2_kind_r    <= kind_c;
      s2_a_sum_r   <= a_sum_c;
      s2_b_sum_r   <= b_sum_c;
      s2_lin_sum_r <= lin_sum_c;
      s2_iv_r      <= iv_c;
      s2_vf_r      <= s1_vf_r;
      s2_d00_r     <= s1_d00_r;
      s2_rf_r      <= s1_rf_r;
      s2_noise_r   <= s1_noise_r;

      s3_kind_r    <= s2_kind_r;
      s3_bil_sum_r <= bil_sum_c;
      s3_lin_sum_r <= s2_lin_sum_r;
      s3_d00_r     <= s2_d00_r;
      s3_rf_r      <= s2_rf_r;
      s3_noise_r   <= s2_noise_r;

      s4_kind_r <= s3_kind_r;
      s4_d_r    <= d_c;
      s4_ok_r   <= ok_c;
      s4_rf_r   <= s3_rf_r;

      s5_kind_r <= s4_kind_r;
      s5_d_r    <= s4_d_r;
      s5_ok_r   <= s4_ok_r;
      s5_prod_r <= RPROD_W'(s4_d_r) * RPROD_W'(s4_rf_r);

      out_kind_r  <= s5_kind_r;
      out_res_r   <= res_ok_c;
      out_range_r <= res_ok_c ? rng_c : '0;
      out_depth_r <= res_ok_c ? s5_d_r : '0;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_range_out   = out_range_r;
  assign out_depth_out   = out_depth_r;
  assign out_valid_res   = out_res_r;
  assign out_interp_kind = out_kind_r;

endmodule
